FILE: src/sch_pkg.sv
// ----------------------------------------------------------------------------
// sch_pkg: shared types, constants and functions for the name hash block
// The package holds the CRC-32C byte update, the separator test and the key
// layout constants.
// ----------------------------------------------------------------------------
package sch_pkg;

	localparam logic [31:0] CRC_POLY  = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [31:0] KEY_TOP   = 32'h8000_0000;
	localparam logic [14:0] KEY_LOW_ZERO = 15'h0000;

	localparam logic [7:0] SEP_DOT   = 8'h2E;
	localparam logic [7:0] SEP_DASH  = 8'h2D;
	localparam logic [7:0] SEP_UNDER = 8'h5F;
	localparam logic [7:0] SEP_TILDE = 8'h7E;

	typedef logic [7:0]  byte_t;
	typedef logic [31:0] crc_t;
	typedef logic [63:0] key_t;

	typedef struct packed {
		logic  adv;
		logic  last;
		byte_t data;
	} step_t;

	function automatic crc_t crc_byte(input crc_t crc_in, input byte_t b);
		crc_t c;
		c = crc_in ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic is_sep(input byte_t b);
		return (b == SEP_DOT) || (b == SEP_DASH) || (b == SEP_UNDER) || (b == SEP_TILDE);
	endfunction

endpackage

FILE: src/sch_core.sv
// ----------------------------------------------------------------------------
// sch_core: running hash state and key formation
// Holds the segment CRC, the whole-name CRC, the segment sum and the
// non-empty flag, updates them for one byte per step and forms the key
// for a byte that ends the name.
// ----------------------------------------------------------------------------
module sch_core (
	input  logic          clk,
	input  logic          arst_n,
	input  sch_pkg::step_t step,
	output sch_pkg::key_t  key
);
	import sch_pkg::*;

	crc_t seg_crc_q;
	crc_t whole_crc_q;
	crc_t seg_sum_q;
	logic nonempty_q;

	crc_t whole_next;
	crc_t seg_upd;
	crc_t addend;
	crc_t sum_next;
	crc_t whole_fin;
	logic sep;

	always_comb begin
		sep        = is_sep(step.data);
		whole_next = crc_byte(whole_crc_q, step.data);
		seg_upd    = crc_byte(seg_crc_q, step.data);
		if (sep) begin
			addend = nonempty_q ? ~seg_crc_q : '0;
		end else begin
			addend = step.last ? ~seg_upd : '0;
		end
		sum_next  = seg_sum_q + addend;
		whole_fin = ~whole_next;
		key = {sum_next | KEY_TOP, whole_fin[31:16] ^ whole_fin[15:0], 1'b1, KEY_LOW_ZERO};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_crc_q   <= CRC_INIT;
			whole_crc_q <= CRC_INIT;
			seg_sum_q   <= '0;
			nonempty_q  <= 1'b0;
		end else if (step.adv) begin
			if (step.last) begin
				seg_crc_q   <= CRC_INIT;
				whole_crc_q <= CRC_INIT;
				seg_sum_q   <= '0;
				nonempty_q  <= 1'b0;
			end else begin
				whole_crc_q <= whole_next;
				seg_sum_q   <= sum_next;
				if (sep) begin
					seg_crc_q  <= CRC_INIT;
					nonempty_q <= 1'b0;
				end else begin
					seg_crc_q  <= seg_upd;
					nonempty_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: src/segmented_crc32c_name_hash.sv
// ----------------------------------------------------------------------------
// segmented_crc32c_name_hash: segmented CRC-32C directory key
// Takes a filename one byte per word and returns a 64-bit key on the last
// byte of each name.
//
//   Port group  Dir  Payload
//   s_*         in   tdata[7:0] name_byte, tlast last_byte
//   m_*         out  tdata[63:0] hash_key
//
// A byte is registered in the input register on acceptance and processed from
// there, one byte per clock unless a stalled key holds it; the key register
// loads the key when its last byte is processed. The byte-wide CRC-32C update
// followed by the 32-bit sum add sets the clock. Reset returns the hash state
// to the start of a name. A stalled key holds only a last byte in the input
// register behind it; other bytes keep flowing.
// ----------------------------------------------------------------------------
module segmented_crc32c_name_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] name_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [63:0] hash_key
);
	import sch_pkg::*;

	logic  valid_s1;
	logic  last_s1;
	byte_t data_s1;
	logic  out_valid_q;
	key_t  key_q;
	key_t  key;
	step_t step;

	assign step.adv  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign step.last = last_s1;
	assign step.data = data_s1;
	assign s_tready  = !valid_s1 || step.adv;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = key_q;

	sch_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.key    (key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.adv && step.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.adv && step.last) begin
			key_q <= key;
		end
	end

endmodule

FILE: bench/name_key_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// name_key_checker: directory key scoreboard for the name hash block
// Watches both stream channels. Every accepted input word updates a local
// copy of the segment and whole-name CRC state; the last byte of a name
// queues the key it should produce. Every accepted output word is compared
// with the oldest queued key.
// ----------------------------------------------------------------------------
module name_key_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	output int          mismatches,
	output int          keys_outstanding
);

	import sch_pkg::*;

	crc_t seg_crc = CRC_INIT;
	crc_t name_crc = CRC_INIT;
	crc_t seg_sum = '0;
	logic seg_open = 1'b0;
	key_t expected_keys[$];

	function automatic crc_t crc32c_step(input crc_t crc_in, input byte_t d);
		crc_t r;
		logic fb;
		r = crc_in;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ d[i];
			r = r >> 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	function automatic logic splits_name(input byte_t d);
		case (d)
			SEP_DOT, SEP_DASH, SEP_UNDER, SEP_TILDE: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic key_t dir_key(input crc_t sum, input crc_t name_fin);
		return {sum | KEY_TOP, name_fin[31:16] ^ name_fin[15:0], 1'b1, KEY_LOW_ZERO};
	endfunction

	task automatic report(input string what);
		$display("%0t ns mismatch: %s", $time, what);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		keys_outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin : track
		crc_t seg_next;
		crc_t sum_next;
		crc_t name_next;
		logic open_next;
		key_t want;
		if (!arst_n) begin
			seg_crc = CRC_INIT;
			name_crc = CRC_INIT;
			seg_sum = '0;
			seg_open = 1'b0;
			expected_keys.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				name_next = crc32c_step(name_crc, s_tdata);
				seg_next = seg_crc;
				sum_next = seg_sum;
				open_next = seg_open;
				if (splits_name(s_tdata)) begin
					if (open_next) begin
						sum_next = sum_next + ~seg_next;
					end
					seg_next = CRC_INIT;
					open_next = 1'b0;
				end else begin
					seg_next = crc32c_step(seg_next, s_tdata);
					open_next = 1'b1;
				end
				if (s_tlast) begin
					if (open_next) begin
						sum_next = sum_next + ~seg_next;
					end
					expected_keys.push_back(dir_key(sum_next, ~name_next));
					seg_crc = CRC_INIT;
					name_crc = CRC_INIT;
					seg_sum = '0;
					seg_open = 1'b0;
				end else begin
					seg_crc = seg_next;
					name_crc = name_next;
					seg_sum = sum_next;
					seg_open = open_next;
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_keys.size() == 0) begin
					report($sformatf("key %h with no name pending", m_tdata));
				end else begin
					want = expected_keys.pop_front();
					if (m_tdata !== want) begin
						report($sformatf("hash_key got %h want %h", m_tdata, want));
					end
				end
			end
		end
		keys_outstanding = expected_keys.size();
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the segmented name hash block
// Sends filenames one byte per word, first a handful of hand-picked names
// (extreme bytes, lone and repeated separators, names of separators only),
// then random names rich in separators. The sender works in bursts and the
// receiver stalls in changing patterns, with one long hold-off that backs
// the block up. The checker beside the block predicts and compares keys.
// ----------------------------------------------------------------------------
module testbench;

	import sch_pkg::*;

	localparam int ITEM_TARGET  = 1050;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES  = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;

	int mismatches;
	int keys_outstanding;
	int cycles = 0;
	int burst_left = 0;
	int items_sent = 0;
	bit hold_wanted = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int rx_mode = 0;
	int rx_left = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	segmented_crc32c_name_hash u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	name_key_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tlast          (s_tlast),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.mismatches       (mismatches),
		.keys_outstanding (keys_outstanding)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_wanted && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(16, 96);
			end
			rx_left--;
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ~m_tready;
			endcase
		end
	end

	task automatic send_byte(input byte_t b, input bit is_last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= is_last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	function automatic byte_t pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			case ($urandom_range(0, 3))
				0: return SEP_DOT;
				1: return SEP_DASH;
				2: return SEP_UNDER;
				default: return SEP_TILDE;
			endcase
		end else if (r < 65) begin
			return 8'h61 + 8'($urandom_range(0, 25));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin : stimulus
		int len;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(SEP_DOT, 1'b1);
		send_byte(SEP_DASH, 1'b0);
		send_byte(SEP_UNDER, 1'b0);
		send_byte(SEP_TILDE, 1'b1);
		send_byte("a", 1'b0);
		send_byte(SEP_DOT, 1'b0);
		send_byte("b", 1'b1);
		send_byte(SEP_DOT, 1'b0);
		send_byte(SEP_DOT, 1'b0);
		send_byte("x", 1'b1);
		send_byte("x", 1'b0);
		send_byte(SEP_TILDE, 1'b1);
		send_byte("A", 1'b0);
		send_byte(SEP_DASH, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(SEP_UNDER, 1'b0);
		send_byte("C", 1'b1);

		while (items_sent < ITEM_TARGET) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64)
			                                   : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				send_byte(pick_byte(), i == len - 1);
				if (items_sent > 400) begin
					hold_wanted = 1'b1;
				end
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (keys_outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
